@@ rtl/mwtn_pkg.sv @@
package mwtn_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int GAIN_BITS       = 17;
  localparam int GAIN_FRAC       = 16;
  localparam int CFG_IDX_BITS    = 8;
  localparam int CFG_DATA_BITS   = 32;

  // Waveform values run from -FS to +FS, one bit wider than a sample
  localparam int WAVE_BITS      = SAMPLE_BITS + 1;
  localparam int PROD_BITS      = WAVE_BITS + GAIN_BITS + 1;
  localparam int SINE_DEPTH     = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_ADDR_BITS = SINE_TABLE_BITS + 1;

  localparam longint Q30_ONE    = longint'(1) << 30;
  localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);

  // Q30 coefficients of sin(pi/2 * x), odd terms x^1 .. x^9
  localparam longint SIN_C0 = 64'sd1686629713;
  localparam longint SIN_C1 = -64'sd693598669;
  localparam longint SIN_C2 = 64'sd85569306;
  localparam longint SIN_C3 = -64'sd5026995;
  localparam longint SIN_C4 = 64'sd172272;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP = 8'd0,
    CFG_GAIN       = 8'd1,
    CFG_WAVE_SEL   = 8'd2,
    CFG_ENABLE     = 8'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          clipped;
  } out_beat_t;

  typedef logic [SAMPLE_BITS-1:0] sine_mag_t;
  typedef sine_mag_t sine_rom_t [SINE_DEPTH];

  // Quarter-wave magnitude: Horner in Q30, each product truncated toward zero
  function automatic sine_mag_t sine_mag(input int idx);
    longint x;
    longint x2;
    longint acc;
    longint r;
    x   = longint'(idx) << (30 - SINE_TABLE_BITS);
    x2  = (x * x) / Q30_ONE;
    acc = SIN_C4;
    acc = SIN_C3 + (acc * x2) / Q30_ONE;
    acc = SIN_C2 + (acc * x2) / Q30_ONE;
    acc = SIN_C1 + (acc * x2) / Q30_ONE;
    acc = SIN_C0 + (acc * x2) / Q30_ONE;
    acc = (acc * x) / Q30_ONE;
    if (acc < 0) acc = 0;
    if (acc > Q30_ONE) acc = Q30_ONE;
    r = (acc * FULL_SCALE + (longint'(1) << 29)) >>> 30;
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      rom[i] = sine_mag(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/multi_waveform_tone_nco.sv @@
// Tone oscillator with additive mixing. Each input beat is one audio sample
// tick; when enabled, a sine (quarter-wave table), square, triangle or
// sawtooth value is formed from the 32-bit phase, scaled by gain (Q1.16,
// 65536 = full scale, rounded half away from zero), added to in_sample and
// saturated to 16 bits with clipped set on saturation. The phase then steps by
// phase_step modulo one cycle; restart clears it before the beat, also when
// disabled. When disabled the sample passes unchanged and the phase holds.
// Throughput is one beat per clock without output stalls; stages: table read, then
// the waveform-times-gain multiply, then round, add and saturate into the
// output register. Stalls on the output back up stage by stage, so empty
// stages still take new beats. Registers: 0 phase_step, 1 gain,
// 2 wave_select, 3 enable; other indexes are ignored. Write registers only
// while the pipeline is empty.
module multi_waveform_tone_nco (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  mwtn_pkg::in_beat_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output mwtn_pkg::out_beat_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mwtn_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [mwtn_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import mwtn_pkg::*;

  localparam int SCALED_BITS = PROD_BITS - GAIN_FRAC + 1;
  localparam int SUM_BITS    = SCALED_BITS + 1;
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_FRAC - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'(FULL_SCALE - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_MIN = -SUM_BITS'(FULL_SCALE);

  // configuration
  logic [PHASE_BITS-1:0] phase_step_q;
  logic [GAIN_BITS-1:0]  gain_q;
  wave_e                 wave_sel_q;
  logic                  enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      gain_q       <= '0;
      wave_sel_q   <= WAVE_SINE;
      enable_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_BITS-1:0];
        CFG_GAIN:       gain_q       <= cfg_data_i[GAIN_BITS-1:0];
        CFG_WAVE_SEL:   wave_sel_q   <= wave_e'(cfg_data_i[1:0]);
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // stage handshake
  logic a_v_q, b_v_q, c_v_q;
  logic a_ld, b_ld, c_ld, in_acc;

  assign c_ld       = !c_v_q || out_ready_i;
  assign b_ld       = !b_v_q || c_ld;
  assign a_ld       = !a_v_q || b_ld;
  assign in_ready_o = a_ld;
  assign in_acc     = in_valid_i && a_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_ld) a_v_q <= in_valid_i;
      if (b_ld) b_v_q <= a_v_q;
      if (c_ld) c_v_q <= b_v_q;
    end
  end

  // stage A: phase and table read
  logic [PHASE_BITS-1:0]         phase_cur;
  logic [PHASE_BITS-1:0]         a_phase_q;
  logic signed [SAMPLE_BITS-1:0] a_sample_q;
  logic                          a_en_q;
  sine_mag_t                     a_mag;

  mwtn_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .restart_i (in_data_i.restart),
    .enable_i  (enable_q),
    .step_i    (phase_step_q),
    .phase_o   (phase_cur)
  );

  mwtn_sine_rom u_sine_rom (
    .clk_i   (clk_i),
    .rd_en_i (in_acc),
    .phase_i (phase_cur),
    .mag_o   (a_mag)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_phase_q  <= phase_cur;
      a_sample_q <= in_data_i.in_sample;
      a_en_q     <= enable_q;
    end
  end

  // stage B: waveform times gain
  logic signed [WAVE_BITS-1:0]   wave;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   b_prod_q;
  logic signed [SAMPLE_BITS-1:0] b_sample_q;
  logic                          b_en_q;

  mwtn_wave u_wave (
    .phase_i    (a_phase_q),
    .sine_mag_i (a_mag),
    .wave_sel_i (wave_sel_q),
    .wave_o     (wave)
  );

  assign prod = PROD_BITS'(wave * $signed({1'b0, gain_q}));

  always_ff @(posedge clk_i) begin
    if (b_ld && a_v_q) begin
      b_prod_q   <= prod;
      b_sample_q <= a_sample_q;
      b_en_q     <= a_en_q;
    end
  end

  // stage C: round half away from zero, mix, saturate
  logic [PROD_BITS-1:0]         prod_mag;
  logic [PROD_BITS-1:0]         prod_rnd;
  logic signed [SCALED_BITS-1:0] scaled;
  logic signed [SUM_BITS-1:0]   sum;
  out_beat_t                    res;
  out_beat_t                    out_q;

  assign prod_mag = b_prod_q[PROD_BITS-1] ? PROD_BITS'(-b_prod_q) : PROD_BITS'(b_prod_q);
  assign prod_rnd = (prod_mag + ROUND_HALF) >> GAIN_FRAC;
  assign scaled   = b_prod_q[PROD_BITS-1] ? -$signed(prod_rnd[SCALED_BITS-1:0])
                                          : $signed(prod_rnd[SCALED_BITS-1:0]);
  assign sum      = SUM_BITS'(b_sample_q) + SUM_BITS'(scaled);

  always_comb begin
    res.out_sample = b_sample_q;
    res.clipped    = 1'b0;
    if (b_en_q) begin
      if (sum > SAT_MAX) begin
        res.out_sample = SAT_MAX[SAMPLE_BITS-1:0];
        res.clipped    = 1'b1;
      end else if (sum < SAT_MIN) begin
        res.out_sample = SAT_MIN[SAMPLE_BITS-1:0];
        res.clipped    = 1'b1;
      end else begin
        res.out_sample = sum[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ld && b_v_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = c_v_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/mwtn_phase.sv @@
module mwtn_phase (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           restart_i,
  input  logic                           enable_i,
  input  logic [mwtn_pkg::PHASE_BITS-1:0] step_i,
  output logic [mwtn_pkg::PHASE_BITS-1:0] phase_o
);
  import mwtn_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d;

  // phase seen by this beat: restart clears it first, even when disabled
  assign phase_o = restart_i ? '0 : phase_q;

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      phase_d = enable_i ? phase_o + step_i : phase_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/mwtn_sine_rom.sv @@
module mwtn_sine_rom (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [mwtn_pkg::PHASE_BITS-1:0] phase_i,
  output mwtn_pkg::sine_mag_t             mag_o
);
  import mwtn_pkg::*;

  logic                       odd_quarter;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_ADDR_BITS-1:0]  addr;
  sine_mag_t                  mag_q;

  assign odd_quarter = phase_i[PHASE_BITS-2];
  assign idx         = phase_i[PHASE_BITS-3 -: SINE_TABLE_BITS];

  // odd quarters run the table backwards, from N down to 1
  assign addr = odd_quarter
              ? (SINE_ADDR_BITS'(1) << SINE_TABLE_BITS) - {1'b0, idx}
              : {1'b0, idx};

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q <= SINE_ROM[addr];
    end
  end

  assign mag_o = mag_q;

endmodule

@@ rtl/mwtn_wave.sv @@
module mwtn_wave (
  input  logic [mwtn_pkg::PHASE_BITS-1:0]       phase_i,
  input  mwtn_pkg::sine_mag_t                   sine_mag_i,
  input  mwtn_pkg::wave_e                       wave_sel_i,
  output logic signed [mwtn_pkg::WAVE_BITS-1:0] wave_o
);
  import mwtn_pkg::*;

  localparam logic signed [WAVE_BITS+1:0] FS_W  = (WAVE_BITS+2)'(FULL_SCALE);
  localparam logic signed [WAVE_BITS+1:0] FS2_W = (WAVE_BITS+2)'(2 * FULL_SCALE);
  localparam logic signed [WAVE_BITS+1:0] FS3_W = (WAVE_BITS+2)'(3 * FULL_SCALE);
  localparam logic signed [WAVE_BITS+1:0] FS4_W = (WAVE_BITS+2)'(4 * FULL_SCALE);

  logic                         sine_neg;
  logic signed [WAVE_BITS-1:0]  sine_w;
  logic signed [WAVE_BITS-1:0]  square_w;
  logic [SAMPLE_BITS:0]         tri_u;
  logic signed [WAVE_BITS+1:0]  tri_x;
  logic signed [WAVE_BITS+1:0]  tri_w;
  logic signed [WAVE_BITS-1:0]  saw_w;

  assign sine_neg = phase_i[PHASE_BITS-1];
  assign sine_w   = sine_neg ? -$signed({1'b0, sine_mag_i}) : $signed({1'b0, sine_mag_i});

  assign square_w = phase_i[PHASE_BITS-1] ? -WAVE_BITS'(FULL_SCALE) : WAVE_BITS'(FULL_SCALE);

  // triangle rises to +FS at a quarter, falls to -FS at three quarters
  assign tri_u = phase_i[PHASE_BITS-1 -: SAMPLE_BITS+1];
  assign tri_x = $signed({2'b00, tri_u});
  always_comb begin
    if (tri_x < FS_W) begin
      tri_w = tri_x;
    end else if (tri_x < FS3_W) begin
      tri_w = FS2_W - tri_x;
    end else begin
      tri_w = tri_x - FS4_W;
    end
  end

  assign saw_w = $signed({1'b0, phase_i[PHASE_BITS-1 -: SAMPLE_BITS]})
               - WAVE_BITS'(FULL_SCALE);

  always_comb begin
    unique case (wave_sel_i)
      WAVE_SINE:     wave_o = sine_w;
      WAVE_SQUARE:   wave_o = square_w;
      WAVE_TRIANGLE: wave_o = tri_w[WAVE_BITS-1:0];
      WAVE_SAWTOOTH: wave_o = saw_w;
      default:       wave_o = '0;
    endcase
  end

endmodule
